FILE: hdl/lsd_pkg.sv
// Shared constants and types for the decimal radix sorter.
package lsd_pkg;

  localparam int VALUE_W      = 31;
  localparam int MAX_ELEMENTS = 64;
  localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
  localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
  localparam int RADIX        = 10;
  localparam int DIGIT_W      = $clog2(RADIX);
  localparam int PASS_CAP     = 10;
  localparam int PASS_W       = $clog2(PASS_CAP + 1);
  localparam int PLACE_W      = 30;

  // Reciprocal of ten: floor(q * RECIP / 2^RECIP_SHIFT) == q / 10 for q < 2^32
  localparam int           RECIP_W     = 32;
  localparam logic [31:0]  RECIP       = 32'hCCCC_CCCD;
  localparam int           RECIP_SHIFT = 35;
  localparam int           PROD_W      = VALUE_W + RECIP_W;
  localparam int           QUO_W       = PROD_W - RECIP_SHIFT;

  // One stored element: its value and its quotient by the current place
  typedef struct packed {
    logic [VALUE_W-1:0] quo;
    logic [VALUE_W-1:0] value;
  } entry_t;

  // Access request to the ping-pong element store
  typedef struct packed {
    logic              wr_en;
    logic              wr_bank;
    logic [ADDR_W-1:0] wr_addr;
    entry_t            wr_data;
    logic              rd_en;
    logic              rd_bank;
    logic [ADDR_W-1:0] rd_addr;
  } store_req_t;

endpackage

FILE: hdl/lsd_store.sv
// Two-bank element store: one write port and one registered read port.
module lsd_store (
  input  logic               clk,
  input  lsd_pkg::store_req_t req,
  output lsd_pkg::entry_t    rd_data
);
  import lsd_pkg::*;

  entry_t bank0_mem [MAX_ELEMENTS];
  entry_t bank1_mem [MAX_ELEMENTS];
  entry_t rd_data_r;

  // Write bank zero
  always_ff @(posedge clk) begin
    if (req.wr_en && !req.wr_bank) begin
      bank0_mem[req.wr_addr] <= req.wr_data;
    end
  end

  // Write bank one
  always_ff @(posedge clk) begin
    if (req.wr_en && req.wr_bank) begin
      bank1_mem[req.wr_addr] <= req.wr_data;
    end
  end

  // Register the read data; hold it between reads
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= req.rd_bank ? bank1_mem[req.rd_addr] : bank0_mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hdl/lsd_div10.sv
// Shared divide-by-ten unit: registered reciprocal product, then digit and quotient.
module lsd_div10 (
  input  logic                          clk,
  input  logic [lsd_pkg::VALUE_W-1:0]   q,
  output logic [lsd_pkg::DIGIT_W-1:0]   digit,
  output logic [lsd_pkg::VALUE_W-1:0]   quo
);
  import lsd_pkg::*;

  logic [PROD_W-1:0]  prod;
  logic [QUO_W-1:0]   quo_r;
  logic [DIGIT_W-1:0] q_lo_r;
  logic [DIGIT_W-1:0] ten_lo;

  // Multiply by the reciprocal of ten
  assign prod = q * RECIP;

  always_ff @(posedge clk) begin
    quo_r  <= prod[RECIP_SHIFT +: QUO_W];
    q_lo_r <= q[DIGIT_W-1:0];
  end

  // Remainder is below sixteen, so the low bits of q - 10*quo suffice
  assign ten_lo = DIGIT_W'({quo_r, 3'b000}) + DIGIT_W'({quo_r, 1'b0});
  assign digit  = q_lo_r - ten_lo;
  assign quo    = VALUE_W'(quo_r);

endmodule

FILE: hdl/lsd_radix_sort_base10.sv
// Top level: batch loader, pass sequencer and output register of the radix sorter.
//
// Usage: a batch of non-negative values enters on the in_ channel, one request
// per cycle while in_ready is high; the request with in_last set closes the
// batch. Up to 64 values are held; later values of the batch are dropped.
// in_ready then falls and the block sorts. Each pass has a decision step,
// a counting sweep that reads all n values, ten prefix-sum steps and a
// scatter sweep that reads all n values in reverse; each sweep then drains
// the store read register and the divider register. Both sweeps use the
// single read port of the store, which feeds the shared divide-by-ten unit.
// Passes run while the place value does not exceed the batch maximum, at most
// ten. Results leave on the out_ channel in ascending order, each read from
// the store before it is loaded, with out_last_out on the final one. A stalled
// receiver simply holds the output register and pauses the read-out. in_ready
// rises again together with the final result, so the next batch may load
// while it waits. Reset (synchronous, rst_n low) empties the batch; stored
// data is not cleared.
module lsd_radix_sort_base10 (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [lsd_pkg::VALUE_W-1:0] in_value,
  input  logic                        in_last,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [lsd_pkg::VALUE_W-1:0] out_sorted_value,
  output logic                        out_last_out
);
  import lsd_pkg::*;

  typedef enum logic [2:0] {
    S_LOAD, S_CHECK, S_COUNT, S_PREFIX, S_SCATTER, S_EMIT_RD, S_EMIT_LD
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [VALUE_W-1:0] max_r, max_nxt;
  logic [PLACE_W-1:0] place_r, place_nxt;
  logic [PASS_W-1:0]  passes_r, passes_nxt;
  logic               bank_r, bank_nxt;
  logic [ADDR_W-1:0]  iss_idx_r, iss_idx_nxt;
  logic [CNT_W-1:0]   iss_left_r, iss_left_nxt;
  logic               s1_v_r, s1_v_nxt, s1_tail_r, s1_tail_nxt;
  logic               s2_v_r, s2_v_nxt, s2_tail_r, s2_tail_nxt;
  logic [VALUE_W-1:0] s2_value_r, s2_value_nxt;
  logic [CNT_W-1:0]   cnt_r [RADIX];
  logic [CNT_W-1:0]   cnt_nxt [RADIX];
  logic [CNT_W-1:0]   acc_r, acc_nxt;
  logic [DIGIT_W-1:0] k_r, k_nxt;
  logic [ADDR_W-1:0]  em_idx_r, em_idx_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0] out_value_r, out_value_nxt;
  logic               out_last_r, out_last_nxt;

  store_req_t         req;
  entry_t             rd_data;
  logic [DIGIT_W-1:0] div_digit;
  logic [VALUE_W-1:0] div_quo;
  logic [DIGIT_W-1:0] cnt_idx;
  logic [CNT_W-1:0]   cnt_rd;
  logic [CNT_W-1:0]   acc_sum;
  logic [CNT_W-1:0]   cnt_dec;
  logic               em_last;

  lsd_store u_store (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  lsd_div10 u_div10 (
    .clk   (clk),
    .q     (rd_data.quo),
    .digit (div_digit),
    .quo   (div_quo)
  );

  // One read address into the digit counters
  assign cnt_idx = (state_r == S_PREFIX) ? k_r : div_digit;
  assign cnt_rd  = cnt_r[cnt_idx];
  assign acc_sum = acc_r + cnt_rd;
  assign cnt_dec = cnt_rd - CNT_W'(1);
  assign em_last = ({1'b0, em_idx_r} == (count_r - CNT_W'(1)));

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    max_nxt      = max_r;
    place_nxt    = place_r;
    passes_nxt   = passes_r;
    bank_nxt     = bank_r;
    iss_idx_nxt  = iss_idx_r;
    iss_left_nxt = iss_left_r;
    cnt_nxt      = cnt_r;
    acc_nxt      = acc_r;
    k_nxt        = k_r;
    em_idx_nxt   = em_idx_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;

    req         = '0;
    req.rd_bank = bank_r;
    req.wr_bank = ~bank_r;

    // Advance the read pipeline
    s1_v_nxt     = 1'b0;
    s1_tail_nxt  = 1'b0;
    s2_v_nxt     = s1_v_r;
    s2_tail_nxt  = s1_tail_r;
    s2_value_nxt = rd_data.value;

    // Drop the output request once taken
    out_valid_nxt = out_valid_r && !out_ready;

    // Issue one read per cycle during the counting and scatter sweeps
    if ((state_r == S_COUNT || state_r == S_SCATTER) && iss_left_r != '0) begin
      req.rd_en    = 1'b1;
      req.rd_addr  = iss_idx_r;
      s1_v_nxt     = 1'b1;
      s1_tail_nxt  = (iss_left_r == CNT_W'(1));
      iss_left_nxt = iss_left_r - CNT_W'(1);
      iss_idx_nxt  = (state_r == S_COUNT) ? iss_idx_r + ADDR_W'(1)
                                          : iss_idx_r - ADDR_W'(1);
    end

    case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          if (count_r < CNT_W'(MAX_ELEMENTS)) begin
            req.wr_en         = 1'b1;
            req.wr_bank       = bank_r;
            req.wr_addr       = count_r[ADDR_W-1:0];
            req.wr_data.quo   = in_value;
            req.wr_data.value = in_value;
            count_nxt         = count_r + CNT_W'(1);
            if (in_value > max_r) begin
              max_nxt = in_value;
            end
          end
          if (in_last) begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (passes_r < PASS_W'(PASS_CAP) && max_r >= VALUE_W'(place_r)) begin
          state_nxt    = S_COUNT;
          for (int i = 0; i < RADIX; i++) begin
            cnt_nxt[i] = '0;
          end
          iss_idx_nxt  = '0;
          iss_left_nxt = count_r;
        end else begin
          state_nxt  = S_EMIT_RD;
          em_idx_nxt = '0;
        end
      end
      S_COUNT: begin
        if (s2_v_r) begin
          cnt_nxt[cnt_idx] = cnt_rd + CNT_W'(1);
          if (s2_tail_r) begin
            state_nxt = S_PREFIX;
            k_nxt     = '0;
            acc_nxt   = '0;
          end
        end
      end
      S_PREFIX: begin
        cnt_nxt[cnt_idx] = acc_sum;
        acc_nxt          = acc_sum;
        if (k_r == DIGIT_W'(RADIX - 1)) begin
          state_nxt    = S_SCATTER;
          iss_idx_nxt  = ADDR_W'(count_r - CNT_W'(1));
          iss_left_nxt = count_r;
        end else begin
          k_nxt = k_r + DIGIT_W'(1);
        end
      end
      S_SCATTER: begin
        if (s2_v_r) begin
          cnt_nxt[cnt_idx]  = cnt_dec;
          req.wr_en         = 1'b1;
          req.wr_addr       = cnt_dec[ADDR_W-1:0];
          req.wr_data.quo   = div_quo;
          req.wr_data.value = s2_value_r;
          if (s2_tail_r) begin
            state_nxt  = S_CHECK;
            bank_nxt   = ~bank_r;
            passes_nxt = passes_r + PASS_W'(1);
            if (passes_r + PASS_W'(1) < PASS_W'(PASS_CAP)) begin
              place_nxt = (place_r << 3) + (place_r << 1);
            end
          end
        end
      end
      S_EMIT_RD: begin
        req.rd_en   = 1'b1;
        req.rd_addr = em_idx_r;
        state_nxt   = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = rd_data.value;
          out_last_nxt  = em_last;
          if (em_last) begin
            state_nxt  = S_LOAD;
            count_nxt  = '0;
            max_nxt    = '0;
            place_nxt  = PLACE_W'(1);
            passes_nxt = '0;
          end else begin
            em_idx_nxt = em_idx_r + ADDR_W'(1);
            state_nxt  = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      max_r       <= '0;
      place_r     <= PLACE_W'(1);
      passes_r    <= '0;
      bank_r      <= 1'b0;
      iss_idx_r   <= '0;
      iss_left_r  <= '0;
      s1_v_r      <= 1'b0;
      s1_tail_r   <= 1'b0;
      s2_v_r      <= 1'b0;
      s2_tail_r   <= 1'b0;
      s2_value_r  <= '0;
      for (int i = 0; i < RADIX; i++) begin
        cnt_r[i] <= '0;
      end
      acc_r       <= '0;
      k_r         <= '0;
      em_idx_r    <= '0;
      out_valid_r <= 1'b0;
      out_value_r <= '0;
      out_last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      max_r       <= max_nxt;
      place_r     <= place_nxt;
      passes_r    <= passes_nxt;
      bank_r      <= bank_nxt;
      iss_idx_r   <= iss_idx_nxt;
      iss_left_r  <= iss_left_nxt;
      s1_v_r      <= s1_v_nxt;
      s1_tail_r   <= s1_tail_nxt;
      s2_v_r      <= s2_v_nxt;
      s2_tail_r   <= s2_tail_nxt;
      s2_value_r  <= s2_value_nxt;
      cnt_r       <= cnt_nxt;
      acc_r       <= acc_nxt;
      k_r         <= k_nxt;
      em_idx_r    <= em_idx_nxt;
      out_valid_r <= out_valid_nxt;
      out_value_r <= out_value_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  assign in_ready         = (state_r == S_LOAD);
  assign out_valid        = out_valid_r;
  assign out_sorted_value = out_value_r;
  assign out_last_out     = out_last_r;

endmodule

FILE: hdl/lsd_checker.sv
// Port-level checks for the radix sorter, bound to the top level.
module lsd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_last,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [lsd_pkg::VALUE_W-1:0] out_sorted_value,
  input logic                        out_last_out
);

  // No result pending right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result request present after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sorted_value)
                                && $stable(out_last_out))
    else $error("stalled result changed");

  // Closing a batch stops intake
  a_close_batch: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("input still ready after the closing request");

  // Intake reopens only together with the final result
  a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_ready) && $past(rst_n) |-> out_valid && out_last_out)
    else $error("input reopened without the final result");

  // No result is offered while a batch is loading with no result pending
  a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !($past(in_ready) && !$past(out_valid)) || out_last_out)
    else $error("result offered during batch load");

endmodule

bind lsd_radix_sort_base10 lsd_checker u_lsd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_last          (in_last),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_sorted_value (out_sorted_value),
  .out_last_out     (out_last_out)
);

FILE: bench/testbench.sv
// Self-checking testbench for the decimal radix sorter: random batches against a radix predictor.
module testbench;
  import lsd_pkg::*;

  localparam int HOLD_CYCLES  = 800;
  localparam int DRAIN_CYCLES = 200;
  localparam int CYCLE_LIMIT  = 400000;
  localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               is_last;
  } sorted_item_t;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  logic [VALUE_W-1:0] in_value  = '0;
  logic               in_last   = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [VALUE_W-1:0] out_sorted_value;
  logic               out_last_out;

  // Predictor state: the batch being loaded and the sorted results still owed
  logic [VALUE_W-1:0] batch_values [MAX_ELEMENTS];
  int unsigned        batch_count = 0;
  logic [VALUE_W-1:0] batch_max   = '0;
  sorted_item_t       pending_sorted [$];

  // Sender and receiver pacing
  int  error_count   = 0;
  int  cycle_count   = 0;
  int  burst_left    = 0;
  bit  gaps_on       = 1'b0;
  int  stall_pct     = 0;
  int  hold_requests = 0;
  int  hold_served   = 0;
  int  hold_left     = 0;

  lsd_radix_sort_base10 dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_value         (in_value),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sorted_value (out_sorted_value),
    .out_last_out     (out_last_out)
  );

  always #5 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_sorted.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input longint want, input longint got);
    $display("cycle %0d: %s: expected %0d, got %0d", cycle_count, what, want, got);
    error_count++;
  endtask

  // Store one request; on the closing request run the decimal LSD sort and queue its output
  function automatic void predict_request(input logic [VALUE_W-1:0] value, input logic is_last);
    logic [VALUE_W-1:0] scratch [MAX_ELEMENTS];
    int unsigned        bucket_end [RADIX];
    int unsigned        place;
    int unsigned        passes;
    int unsigned        digit;
    int                 i;
    sorted_item_t       item;
    // drop requests beyond a full batch, maximum untouched
    if (batch_count < MAX_ELEMENTS) begin
      batch_values[batch_count] = value;
      batch_count++;
      if (value > batch_max) batch_max = value;
    end
    if (!is_last) return;
    place  = 1;
    passes = 0;
    while (passes < PASS_CAP && (batch_max / place) > 0) begin
      for (i = 0; i < RADIX; i++) bucket_end[i] = 0;
      for (i = 0; i < batch_count; i++) bucket_end[(batch_values[i] / place) % RADIX]++;
      for (i = 1; i < RADIX; i++) bucket_end[i] += bucket_end[i-1];
      // scatter backwards to keep equal digits in order
      for (i = batch_count - 1; i >= 0; i--) begin
        digit = (batch_values[i] / place) % RADIX;
        bucket_end[digit]--;
        scratch[bucket_end[digit]] = batch_values[i];
      end
      for (i = 0; i < batch_count; i++) batch_values[i] = scratch[i];
      passes++;
      if (passes < PASS_CAP) place *= RADIX;
    end
    for (i = 0; i < batch_count; i++) begin
      item.value   = batch_values[i];
      item.is_last = (i == batch_count - 1);
      pending_sorted.push_back(item);
    end
    batch_count = 0;
    batch_max   = '0;
  endfunction

  // Offer one request, hold it until accepted, then, with gaps on, pause between bursts
  task automatic send_item(input logic [VALUE_W-1:0] value, input logic is_last);
    in_valid <= 1'b1;
    in_value <= value;
    in_last  <= is_last;
    do @(posedge clk); while (!in_ready);
    predict_request(value, is_last);
    if (gaps_on && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end else if (burst_left > 0) begin
      burst_left--;
    end
  endtask

  // Mix of single digits, small numbers, powers of ten and full-range values
  function automatic logic [VALUE_W-1:0] pick_value();
    int unsigned power;
    int          k;
    power = 1;
    case ($urandom_range(0, 3))
      0: return VALUE_W'($urandom_range(0, 9));
      1: return VALUE_W'($urandom_range(0, 9999));
      2: begin
        k = $urandom_range(0, 9);
        repeat (k) power *= 10;
        return VALUE_W'(power - 1 + $urandom_range(0, 2));
      end
      default: return VALUE_W'($urandom());
    endcase
  endfunction

  // Drive out_ready: long hold-offs on request, otherwise random stalls
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_left   = HOLD_CYCLES;
      hold_served = hold_requests;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Compare each accepted result with the oldest sorted value owed
  always @(posedge clk) begin : check_results
    sorted_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_sorted.size() == 0) begin
        report_mismatch("unexpected result", longint'(-1), longint'(out_sorted_value));
      end else begin
        want = pending_sorted.pop_front();
        if (out_sorted_value !== want.value)
          report_mismatch("out_sorted_value", longint'(want.value),
                          longint'(out_sorted_value));
        if (out_last_out !== want.is_last)
          report_mismatch("out_last_out", longint'(want.is_last), longint'(out_last_out));
      end
    end
  end

  // One-element batches at both ends of the range
  task automatic test_single_values();
    gaps_on   = 1'b0;
    stall_pct = 0;
    send_item('0, 1'b1);
    send_item(VALUE_MAX, 1'b1);
  endtask

  // Ten-digit values force the full pass count; duplicates check stability
  task automatic test_digit_extremes();
    gaps_on   = 1'b1;
    stall_pct = 30;
    send_item(VALUE_MAX, 1'b0);
    send_item('0, 1'b0);
    send_item(31'd1000000000, 1'b0);
    send_item(31'd999999999, 1'b0);
    send_item(31'd1, 1'b0);
    send_item(31'd10, 1'b0);
    send_item(31'd9, 1'b0);
    send_item(VALUE_MAX, 1'b0);
    send_item(31'd5, 1'b0);
    send_item(31'h4000_0000, 1'b1);
  endtask

  // All-zero batch runs no pass; single-digit batch runs one
  task automatic test_low_maximum();
    send_item('0, 1'b0);
    send_item('0, 1'b0);
    send_item('0, 1'b1);
    send_item(31'd7, 1'b0);
    send_item(31'd3, 1'b0);
    send_item(31'd7, 1'b0);
    send_item('0, 1'b1);
  endtask

  // Mostly short batches, some longer, with changing pacing
  task automatic test_random_batches();
    int sent;
    int size;
    int i;
    sent = 0;
    while (sent < 90) begin
      size      = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      gaps_on   = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 2))
        0: stall_pct = 0;
        1: stall_pct = 25;
        default: stall_pct = 60;
      endcase
      for (i = 0; i < size; i++) send_item(pick_value(), i == size - 1);
      sent += size;
    end
  endtask

  // Overfill the batch; dropped requests carry the largest value and the last mark
  task automatic test_overflow_batch();
    int i;
    gaps_on   = 1'b1;
    stall_pct = 20;
    for (i = 0; i < MAX_ELEMENTS; i++) send_item(pick_value(), 1'b0);
    for (i = 0; i < 6; i++) send_item(VALUE_MAX, i == 5);
  endtask

  // Hold off the receiver so the full batch backs up and the next one stalls at the input
  task automatic test_input_backpressure();
    int i;
    stall_pct = 0;
    hold_requests++;
    for (i = 0; i < MAX_ELEMENTS; i++)
      send_item(VALUE_W'($urandom_range(0, 999)), i == MAX_ELEMENTS - 1);
    for (i = 0; i < 20; i++) send_item(pick_value(), i == 19);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_single_values();
    test_digit_extremes();
    test_low_maximum();
    test_random_batches();
    test_overflow_batch();
    test_input_backpressure();
    in_valid <= 1'b0;
    // drain, then watch for stray results
    while (pending_sorted.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_sorted.size() != 0)
      report_mismatch("results never sent", longint'(0), longint'(pending_sorted.size()));
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
